>>> src/ams_pkg.sv
package ams_pkg;

    localparam int ENCODER_RESOLUTION = 1000;
    localparam int SETTLE_TICKS       = 10;
    localparam int TOL_DIVISOR        = 10;

    localparam int POS_W      = 20;
    localparam int CNT_W      = 32;
    localparam int ERR_W      = 16;
    localparam int RATIO_W    = 8;
    localparam int SETTLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int WIDE_W     = 60;
    localparam int DELTA_W    = CNT_W + 1;
    localparam int PROD_W     = DELTA_W + RATIO_W + 1;

    localparam int MAX_ERR_RESET = 100;
    localparam int RATIO_RESET   = 2;

    // x / TOL_DIVISOR as (x * TOL_MUL) >> TOL_SHIFT, exact for ERR_W-bit x
    localparam int     TOL_LOG   = $clog2(TOL_DIVISOR);
    localparam int     TOL_SHIFT = ERR_W + TOL_LOG;
    localparam longint TOL_MUL   = ((longint'(1) << TOL_SHIFT) + TOL_DIVISOR - 1) / TOL_DIVISOR;
    localparam int     TOL_MUL_W = ERR_W + 1;
    localparam int     TOL_PROD_W = ERR_W + TOL_MUL_W;
    localparam int     TOL_RESET = MAX_ERR_RESET / TOL_DIVISOR;

    typedef enum logic {
        CMD_ENTER = 1'b0,
        CMD_TICK  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        MS_OTHER       = 2'd0,
        MS_GOING_READY = 2'd1,
        MS_READY       = 2'd2,
        MS_ALARM       = 2'd3
    } t_mstate;

    typedef enum logic [1:0] {
        NX_STAY   = 2'd0,
        NX_READY  = 2'd1,
        NX_RETURN = 2'd2,
        NX_ALARM  = 2'd3
    } t_next;

    typedef enum logic [1:0] {
        RSN_NONE    = 2'd0,
        RSN_SERVO   = 2'd1,
        RSN_CONTACT = 2'd2
    } t_reason;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_READY_OFFSET     = 3'd0,
        CFG_CONTACT_POSITION = 3'd1,
        CFG_READY_ENABLE     = 3'd2,
        CFG_LEAST_OFFSET     = 3'd3,
        CFG_MAX_SERVO_ERROR  = 3'd4,
        CFG_CONTACT_RATIO    = 3'd5,
        CFG_RAMP_TRAVEL      = 3'd6,
        CFG_MAX_COMPRESSION  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic                    command;
        logic [1:0]              master_state;
        logic                    move_done;
        logic signed [CNT_W-1:0] linear_count;
        logic signed [CNT_W-1:0] rotary_count;
    } t_in_item;

    typedef struct packed {
        logic             set_target;
        logic [POS_W-1:0] servo_target;
        logic             servo_stop;
        logic [1:0]       next_state;
        logic [1:0]       alarm_reason;
        logic             clear_homed;
        logic             clear_contact;
    } t_out_item;

    typedef struct packed {
        logic [POS_W-1:0]   ready_offset;
        logic [POS_W-1:0]   contact_position;
        logic               ready_enable;
        logic [ERR_W-1:0]   least_offset;
        logic [ERR_W-1:0]   tol;
        logic [RATIO_W-1:0] contact_ratio;
        logic [ERR_W-1:0]   ramp_travel;
        logic [ERR_W-1:0]   max_compression;
    } t_cfg;

    typedef struct packed {
        logic signed [CNT_W-1:0] start_count;
        logic signed [CNT_W-1:0] last_rotary;
        logic signed [CNT_W-1:0] last_linear;
        logic [POS_W-1:0]        target;
        logic [SETTLE_W-1:0]     settle;
        logic                    down;
    } t_state;

endpackage

>>> src/ams_ifs.sv
interface ams_in_if;
    logic               valid;
    logic               ready;
    ams_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ams_out_if;
    logic               valid;
    logic               ready;
    ams_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/ams_eval.sv
module ams_eval (
    input  ams_pkg::t_in_item  i_item,
    input  ams_pkg::t_cfg      i_cfg,
    input  ams_pkg::t_state    i_state,
    output ams_pkg::t_out_item o_result,
    output ams_pkg::t_state    o_state
);

    localparam logic signed [ams_pkg::WIDE_W-1:0] RES_W =
        ams_pkg::WIDE_W'(ams_pkg::ENCODER_RESOLUTION);

    logic                                ready_sel;
    logic [ams_pkg::POS_W-1:0]           enter_tgt;
    logic signed [ams_pkg::WIDE_W-1:0]   lin_w;
    logic signed [ams_pkg::WIDE_W-1:0]   rot_w;
    logic signed [ams_pkg::WIDE_W-1:0]   enter_tgt_w;
    logic                                enter_down;
    logic signed [ams_pkg::WIDE_W-1:0]   tgt_w;
    logic signed [ams_pkg::WIDE_W-1:0]   tol_w;
    logic signed [ams_pkg::WIDE_W-1:0]   hi_w;
    logic signed [ams_pkg::WIDE_W-1:0]   lo_w;
    logic                                hi_ok;
    logic                                lo_ok;
    logic [ams_pkg::SETTLE_W-1:0]        settle_dec;
    logic signed [ams_pkg::DELTA_W-1:0]  d_rot;
    logic signed [ams_pkg::DELTA_W-1:0]  d_lin;
    logic signed [ams_pkg::PROD_W-1:0]   ratio_prod;
    logic                                accel_ok;
    logic                                ratio_hit;
    logic                                comp_hit;

    assign lin_w = ams_pkg::WIDE_W'(i_item.linear_count);
    assign rot_w = ams_pkg::WIDE_W'(i_item.rotary_count);

    assign ready_sel = (i_item.master_state == ams_pkg::MS_GOING_READY)
                    && (i_cfg.ready_offset <= i_cfg.contact_position)
                    && i_cfg.ready_enable
                    && (ams_pkg::POS_W'(i_cfg.least_offset) <= i_cfg.ready_offset);
    assign enter_tgt   = ready_sel ? (i_cfg.contact_position - i_cfg.ready_offset) : '0;
    assign enter_tgt_w = ams_pkg::WIDE_W'(enter_tgt);

    // target > trunc(lin / R), without a divider
    assign enter_down = !i_item.linear_count[ams_pkg::CNT_W-1]
                      ? (lin_w < enter_tgt_w * RES_W)
                      : ((enter_tgt != '0) || (lin_w <= -RES_W));

    // final error check: T - tol <= trunc(rot / R) <= T + tol
    assign tgt_w = ams_pkg::WIDE_W'(i_state.target);
    assign tol_w = ams_pkg::WIDE_W'(i_cfg.tol);
    assign hi_w  = tgt_w + tol_w;
    assign lo_w  = tgt_w - tol_w;
    assign hi_ok = i_item.rotary_count[ams_pkg::CNT_W-1] || (rot_w < (hi_w + 1) * RES_W);
    assign lo_ok = !i_item.rotary_count[ams_pkg::CNT_W-1]
                 ? ((lo_w <= 0) || (rot_w >= lo_w * RES_W))
                 : ((lo_w <= 0) && (rot_w > (lo_w - 1) * RES_W));

    assign settle_dec = i_state.settle - 1'b1;

    assign d_rot = ams_pkg::DELTA_W'(i_item.rotary_count) - ams_pkg::DELTA_W'(i_state.last_rotary);
    assign d_lin = ams_pkg::DELTA_W'(i_item.linear_count) - ams_pkg::DELTA_W'(i_state.last_linear);
    assign ratio_prod = ams_pkg::PROD_W'(d_lin) *
                        ams_pkg::PROD_W'($signed({1'b0, i_cfg.contact_ratio}));
    assign accel_ok  = lin_w > (ams_pkg::WIDE_W'(i_state.start_count)
                              + $signed(ams_pkg::WIDE_W'(i_cfg.ramp_travel)) * RES_W);
    assign ratio_hit = (ams_pkg::PROD_W'(d_rot) > ratio_prod) && accel_ok;
    assign comp_hit  = (rot_w - lin_w)
                     > $signed(ams_pkg::WIDE_W'(i_cfg.max_compression)) * RES_W;

    always_comb begin
        o_result = '0;
        o_state  = i_state;
        if (i_item.command == ams_pkg::CMD_ENTER) begin
            o_state.start_count    = i_item.linear_count;
            o_state.last_rotary    = i_item.rotary_count;
            o_state.last_linear    = i_item.linear_count;
            o_state.target         = enter_tgt;
            o_state.settle         = ams_pkg::SETTLE_W'(ams_pkg::SETTLE_TICKS);
            o_state.down           = enter_down;
            o_result.set_target    = 1'b1;
            o_result.servo_target  = enter_tgt;
            o_result.clear_contact = 1'b1;
        end else if (i_item.master_state == ams_pkg::MS_READY) begin
            o_result.servo_stop = 1'b1;
            o_result.next_state = ams_pkg::NX_READY;
        end else if (i_item.master_state == ams_pkg::MS_ALARM) begin
            o_result.servo_stop = 1'b1;
            o_result.next_state = ams_pkg::NX_RETURN;
        end else if (i_item.move_done) begin
            o_state.settle = settle_dec;
            if (settle_dec == '0) begin
                if (hi_ok && lo_ok) begin
                    o_result.next_state = ams_pkg::NX_READY;
                end else begin
                    o_result.next_state   = ams_pkg::NX_ALARM;
                    o_result.alarm_reason = ams_pkg::RSN_SERVO;
                    o_result.clear_homed  = 1'b1;
                end
            end
        end else if (i_state.down) begin
            o_state.last_rotary = i_item.rotary_count;
            o_state.last_linear = i_item.linear_count;
            if (ratio_hit || comp_hit) begin
                o_result.servo_stop   = 1'b1;
                o_result.next_state   = ams_pkg::NX_ALARM;
                o_result.alarm_reason = ams_pkg::RSN_CONTACT;
            end
        end
    end

endmodule

>>> src/actuator_move_supervisor.sv
// Actuator move supervisor.
// i_in (sink) takes one transaction per enter or tick command with the master
// state, the servo move-done flag and both encoder counts. o_out (source)
// returns exactly one result transaction per input: target request, stop
// request, next state, alarm reason and the homed/contact clear flags.
// Configuration is written via i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must do so only while no transaction is in flight, which the block does
// not enforce. The tolerance divide happens at write time. A result passes
// through the input register, one evaluation step and the result register.
// Throughput: one transaction per cycle while the receiver does not stall,
// set by the single evaluation step that reads and updates the move state.
// Reset (synchronous, i_rst_n low) empties both stages, clears the move
// state and loads the configuration defaults.
// When the receiver stalls, the result register holds and the input register,
// if empty, still accepts one more transaction before i_in.ready drops.
module actuator_move_supervisor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ams_in_if.sink                            i_in,
    ams_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [ams_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ams_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic                    r_iv;
    ams_pkg::t_in_item       r_in;
    logic                    r_ov;
    ams_pkg::t_out_item      r_out;
    ams_pkg::t_state         r_state;
    ams_pkg::t_cfg           r_cfg;

    ams_pkg::t_out_item      n_out;
    ams_pkg::t_state         n_state;
    logic                    out_free;
    logic                    in_rdy;
    logic [ams_pkg::TOL_PROD_W-1:0] tol_prod;

    assign out_free    = !r_ov || o_out.ready;
    assign in_rdy      = !r_iv || out_free;
    assign i_in.ready  = in_rdy;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    assign tol_prod = ams_pkg::TOL_PROD_W'(i_cfg_data[ams_pkg::ERR_W-1:0])
                    * ams_pkg::TOL_PROD_W'(ams_pkg::TOL_MUL);

    ams_eval u_eval (
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_result (n_out),
        .o_state  (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv    <= 1'b0;
            r_ov    <= 1'b0;
            r_state <= '0;
        end else begin
            if (in_rdy) begin
                r_iv <= i_in.valid;
            end
            if (out_free) begin
                r_ov <= r_iv;
                if (r_iv) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_rdy && i_in.valid) begin
            r_in <= i_in.data;
        end
        if (out_free && r_iv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ready_offset     <= '0;
            r_cfg.contact_position <= '0;
            r_cfg.ready_enable     <= 1'b0;
            r_cfg.least_offset     <= '0;
            r_cfg.tol              <= ams_pkg::ERR_W'(ams_pkg::TOL_RESET);
            r_cfg.contact_ratio    <= ams_pkg::RATIO_W'(ams_pkg::RATIO_RESET);
            r_cfg.ramp_travel      <= '0;
            r_cfg.max_compression  <= '0;
        end else if (i_cfg_we) begin
            unique case (ams_pkg::t_cfg_idx'(i_cfg_idx))
                ams_pkg::CFG_READY_OFFSET: begin
                    r_cfg.ready_offset <= i_cfg_data[ams_pkg::POS_W-1:0];
                end
                ams_pkg::CFG_CONTACT_POSITION: begin
                    r_cfg.contact_position <= i_cfg_data[ams_pkg::POS_W-1:0];
                end
                ams_pkg::CFG_READY_ENABLE: begin
                    r_cfg.ready_enable <= i_cfg_data[0];
                end
                ams_pkg::CFG_LEAST_OFFSET: begin
                    r_cfg.least_offset <= i_cfg_data[ams_pkg::ERR_W-1:0];
                end
                ams_pkg::CFG_MAX_SERVO_ERROR: begin
                    r_cfg.tol <= ams_pkg::ERR_W'(tol_prod >> ams_pkg::TOL_SHIFT);
                end
                ams_pkg::CFG_CONTACT_RATIO: begin
                    r_cfg.contact_ratio <= i_cfg_data[ams_pkg::RATIO_W-1:0];
                end
                ams_pkg::CFG_RAMP_TRAVEL: begin
                    r_cfg.ramp_travel <= i_cfg_data[ams_pkg::ERR_W-1:0];
                end
                ams_pkg::CFG_MAX_COMPRESSION: begin
                    r_cfg.max_compression <= i_cfg_data[ams_pkg::ERR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    a_enter_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_free && r_iv && r_in.command == ams_pkg::CMD_ENTER)
        |=> (r_state.settle == ams_pkg::SETTLE_W'(ams_pkg::SETTLE_TICKS)))
        else $error("settle count not loaded on enter");

    a_move_xor_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !(r_out.set_target && r_out.servo_stop))
        else $error("move and stop requested together");

    a_homed_servo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.clear_homed)
        |-> (r_out.alarm_reason == ams_pkg::RSN_SERVO && r_out.next_state == ams_pkg::NX_ALARM))
        else $error("clear homed without servo alarm");

    a_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_out.set_target) |-> (r_out.servo_target == '0))
        else $error("target without move request");

    a_stall_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_out.ready) |=> r_ov)
        else $error("result dropped under stall");

endmodule
